### rtl/core/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int OPCODE_W   = 4;
    localparam int LEN_W      = 64;
    localparam int KEY_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_BYTES = 3'd2;
    // Eight extension bytes; the three-bit counter wraps, so zero stands for eight.
    localparam logic [2:0] EXT64_BYTES = 3'd0;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // One queued result: raw byte and mask key byte, unmasked in the back end.
    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   key;
        logic [OPCODE_W-1:0] opcode;
        logic                has_data;
        logic                last;
    } res_entry_t;

endpackage

### rtl/core/wsd_front.sv
// Header parser: walks the frame header and tags each result-bearing byte.
module wsd_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_fire,
    input  logic [wsd_pkg::BYTE_W-1:0] in_byte,
    output logic                      push,
    output wsd_pkg::res_entry_t       push_entry
);

    wsd_pkg::phase_t                 phase_reg, phase_next;
    logic [2:0]                      ext_left_reg, ext_left_next;
    logic [wsd_pkg::LEN_W-1:0]       rem_reg, rem_next;
    logic [wsd_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [2:0]                      key_left_reg, key_left_next;
    logic [1:0]                      pos_reg, pos_next;
    logic                            fin_reg, fin_next;
    logic [wsd_pkg::OPCODE_W-1:0]    opcode_reg, opcode_next;
    logic                            masked_reg, masked_next;

    logic [6:0]                      len7;
    logic                            len_ext;
    logic [2:0]                      ext_dec;
    logic [2:0]                      key_dec;
    logic [wsd_pkg::LEN_W-1:0]       rem_shift;
    logic                            rem_shift_zero;
    logic                            rem_zero;
    logic                            rem_one;
    logic [wsd_pkg::BYTE_W-1:0]      key_byte;

    assign len7           = in_byte[6:0];
    assign len_ext        = (len7 == wsd_pkg::LEN7_EXT16) || (len7 == wsd_pkg::LEN7_EXT64);
    assign ext_dec        = ext_left_reg - 3'd1;
    assign key_dec        = key_left_reg - 3'd1;
    assign rem_shift      = {rem_reg[wsd_pkg::LEN_W-9:0], in_byte};
    assign rem_shift_zero = (rem_shift == '0);
    assign rem_zero       = (rem_reg == '0);
    assign rem_one        = (rem_reg == wsd_pkg::LEN_W'(1));

    always_comb begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            case (phase_reg)
                wsd_pkg::PH_HDR2: begin
                    if (len_ext) begin
                        phase_next = wsd_pkg::PH_EXT;
                    end else if (in_byte[7]) begin
                        phase_next = wsd_pkg::PH_MASK;
                    end else if (len7 == 7'd0) begin
                        phase_next = wsd_pkg::PH_HDR1;
                    end else begin
                        phase_next = wsd_pkg::PH_DATA;
                    end
                end
                wsd_pkg::PH_EXT: begin
                    if (ext_dec == 3'd0) begin
                        if (masked_reg) begin
                            phase_next = wsd_pkg::PH_MASK;
                        end else if (rem_shift_zero) begin
                            phase_next = wsd_pkg::PH_HDR1;
                        end else begin
                            phase_next = wsd_pkg::PH_DATA;
                        end
                    end
                end
                wsd_pkg::PH_MASK: begin
                    if (key_dec == 3'd0) begin
                        phase_next = rem_zero ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_DATA;
                    end
                end
                wsd_pkg::PH_DATA: begin
                    if (rem_one) begin
                        phase_next = wsd_pkg::PH_HDR1;
                    end
                end
                default: begin
                    phase_next = wsd_pkg::PH_HDR2;
                end
            endcase
        end
    end

    // Header state updates and queue writes.
    always_comb begin
        ext_left_next       = ext_left_reg;
        rem_next            = rem_reg;
        key_next            = key_reg;
        key_left_next       = key_left_reg;
        pos_next            = pos_reg;
        fin_next            = fin_reg;
        opcode_next         = opcode_reg;
        masked_next         = masked_reg;
        push                = 1'b0;
        push_entry.data     = '0;
        push_entry.key      = '0;
        push_entry.opcode   = opcode_reg;
        push_entry.has_data = 1'b0;
        push_entry.last     = 1'b1;
        if (in_fire) begin
            case (phase_reg)
                wsd_pkg::PH_HDR2: begin
                    masked_next = in_byte[7];
                    if (len7 == wsd_pkg::LEN7_EXT16) begin
                        rem_next      = '0;
                        ext_left_next = wsd_pkg::EXT16_BYTES;
                    end else if (len7 == wsd_pkg::LEN7_EXT64) begin
                        rem_next      = '0;
                        ext_left_next = wsd_pkg::EXT64_BYTES;
                    end else begin
                        rem_next = wsd_pkg::LEN_W'(len7);
                        if (in_byte[7]) begin
                            key_left_next = wsd_pkg::KEY_BYTES;
                            key_next      = '0;
                        end else begin
                            pos_next = 2'd0;
                            push     = fin_reg && (len7 == 7'd0);
                        end
                    end
                end
                wsd_pkg::PH_EXT: begin
                    rem_next      = rem_shift;
                    ext_left_next = ext_dec;
                    if (ext_dec == 3'd0) begin
                        if (masked_reg) begin
                            key_left_next = wsd_pkg::KEY_BYTES;
                            key_next      = '0;
                        end else begin
                            pos_next = 2'd0;
                            push     = fin_reg && rem_shift_zero;
                        end
                    end
                end
                wsd_pkg::PH_MASK: begin
                    key_next      = {key_reg[wsd_pkg::KEY_W-9:0], in_byte};
                    key_left_next = key_dec;
                    if (key_dec == 3'd0) begin
                        pos_next = 2'd0;
                        push     = fin_reg && rem_zero;
                    end
                end
                wsd_pkg::PH_DATA: begin
                    pos_next            = pos_reg + 2'd1;
                    rem_next            = rem_reg - wsd_pkg::LEN_W'(1);
                    push                = fin_reg;
                    push_entry.data     = in_byte;
                    push_entry.key      = masked_reg ? key_byte : '0;
                    push_entry.has_data = 1'b1;
                    push_entry.last     = rem_one;
                end
                default: begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= wsd_pkg::PH_HDR1;
            ext_left_reg <= '0;
            rem_reg      <= '0;
            key_reg      <= '0;
            key_left_reg <= '0;
            pos_reg      <= '0;
            fin_reg      <= 1'b0;
            opcode_reg   <= '0;
            masked_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            ext_left_reg <= ext_left_next;
            rem_reg      <= rem_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            pos_reg      <= pos_next;
            fin_reg      <= fin_next;
            opcode_reg   <= opcode_next;
            masked_reg   <= masked_next;
        end
    end

endmodule

### rtl/core/wsd_queue.sv
// Short result queue between the header parser and the output stage.
module wsd_queue #(
    parameter int Depth = wsd_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wsd_pkg::res_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output wsd_pkg::res_entry_t head
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    wsd_pkg::res_entry_t slots_reg [Depth];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(Depth));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/wsd_back.sv
// Output stage: unmasks queued bytes into the result register.
module wsd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_not_empty,
    input  wsd_pkg::res_entry_t          q_head,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [wsd_pkg::BYTE_W-1:0]   m_payload_byte,
    output logic [wsd_pkg::OPCODE_W-1:0] m_opcode,
    output logic                         m_has_data,
    output logic                         m_last
);

    logic                         valid_reg;
    logic [wsd_pkg::BYTE_W-1:0]   byte_reg;
    logic [wsd_pkg::OPCODE_W-1:0] opcode_reg;
    logic                         has_data_reg;
    logic                         last_reg;

    // The result register reloads whenever it is empty or being drained.
    assign q_pop = q_not_empty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (!valid_reg || m_ready) begin
            valid_reg <= q_not_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            byte_reg     <= q_head.data ^ q_head.key;
            opcode_reg   <= q_head.opcode;
            has_data_reg <= q_head.has_data;
            last_reg     <= q_head.last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_payload_byte = byte_reg;
    assign m_opcode       = opcode_reg;
    assign m_has_data     = has_data_reg;
    assign m_last         = last_reg;

endmodule

### rtl/core/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  input   | s_valid, s_ready, s_in_byte                       | in
//  result  | m_valid, m_ready, m_payload_byte, m_opcode,        | out
//          | m_has_data, m_last                                |
//
// One byte is taken per clock while s_ready is high; the header parser settles each byte combinationally.
// A result passes through a queue slot and then the result register before it appears.
// Synchronous active-low reset returns the parser to the first header byte and empties the queue.
// A stalled result side backs up the queue of QueueDepth entries, then drops s_ready.
module websocket_frame_deframer #(
    parameter int QueueDepth = wsd_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]   s_in_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [wsd_pkg::BYTE_W-1:0]   m_payload_byte,
    output logic [wsd_pkg::OPCODE_W-1:0] m_opcode,
    output logic                         m_has_data,
    output logic                         m_last
);

    logic                in_fire;
    logic                push;
    wsd_pkg::res_entry_t push_entry;
    logic                q_full;
    logic                q_not_empty;
    logic                q_pop;
    wsd_pkg::res_entry_t q_head;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    wsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_byte    (s_in_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    wsd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    wsd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_opcode       (m_opcode),
        .m_has_data     (m_has_data),
        .m_last         (m_last)
    );

endmodule

### rtl/core/wsd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
module wsd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [wsd_pkg::BYTE_W-1:0]   m_payload_byte,
    input logic [wsd_pkg::OPCODE_W-1:0] m_opcode,
    input logic                         m_has_data,
    input logic                         m_last
);

    // Reset leaves no result transaction pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty-frame result carries no byte and always closes its frame.
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_data) |-> (m_last && (m_payload_byte == '0)))
        else $error("empty-frame result malformed");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result valid dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_payload_byte) && $stable(m_opcode)
                                   && $stable(m_has_data) && $stable(m_last)))
        else $error("result changed while stalled");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
